// ===== rtl/tram_pkg.sv =====
package tram_pkg;

    localparam int IN_IDX_W = 8;
    localparam int DUR_W    = 32;
    localparam int TOT_W    = 64;
    localparam int CNT_W    = 32;
    localparam int AVG_W    = 32;
    localparam int SLOT_W   = 6;
    localparam int ENTRY_W  = TOT_W + CNT_W;
    localparam int STEP_W   = $clog2(TOT_W);

    localparam logic KIND_RECORD   = 1'b0;
    localparam logic KIND_SNAPSHOT = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] idx;
        logic [DUR_W-1:0]  dur;
    } tram_item_t;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_REC_WR  = 6'b000010,
        ST_SNAP_RD = 6'b000100,
        ST_SNAP_LD = 6'b001000,
        ST_SNAP_DV = 6'b010000,
        ST_SPARE   = 6'b100000
    } tram_state_t;

endpackage

// ===== rtl/task_runtime_average_monitor.sv =====
// Channel  | Dir | Handshake        | Transfer when     | Payload
// ---------+-----+------------------+-------------------+----------------------------------
// input    | in  | push / full      | push && !full     | kind, task_index, duration_us
// result   | out | empty / pop      | pop && !empty     | slot, average_us, sample_total, last
//
// Record: into a 2-entry front queue, then a table read and write in the back.
// Snapshot: slot by slot, the entry is read and its average set by the 64-step divider.
// Out-of-range records are taken and dropped in the front queue.
// Reset clears the queues and the per-slot valid bits; the table reads as zero.
// One result register on the output; a snapshot stalls while it is held and not popped.
module task_runtime_average_monitor #(
    parameter int NUM_TASKS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              kind,
    input  logic [tram_pkg::IN_IDX_W-1:0]     task_index,
    input  logic [tram_pkg::DUR_W-1:0]        duration_us,
    output logic                              empty,
    input  logic                              pop,
    output logic [tram_pkg::SLOT_W-1:0]       slot,
    output logic [tram_pkg::AVG_W-1:0]        average_us,
    output logic [tram_pkg::CNT_W-1:0]        sample_total,
    output logic                              last
);
    import tram_pkg::*;

    logic       fq_valid;
    tram_item_t fq_item;
    logic       fq_take;
    logic       out_valid;
    logic       out_take;

    assign empty    = !out_valid;
    assign out_take = pop && out_valid;

    tram_front #(
        .NUM_TASKS (NUM_TASKS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .task_index  (task_index),
        .duration_us (duration_us),
        .fq_valid    (fq_valid),
        .fq_item     (fq_item),
        .fq_take     (fq_take)
    );

    tram_back #(
        .NUM_TASKS (NUM_TASKS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fq_valid     (fq_valid),
        .fq_item      (fq_item),
        .fq_take      (fq_take),
        .out_take     (out_take),
        .out_valid    (out_valid),
        .slot         (slot),
        .average_us   (average_us),
        .sample_total (sample_total),
        .last         (last)
    );

endmodule

// ===== rtl/tram_ram.sv =====
module tram_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tram_front.sv =====
module tram_front #(
    parameter int NUM_TASKS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              kind,
    input  logic [tram_pkg::IN_IDX_W-1:0]     task_index,
    input  logic [tram_pkg::DUR_W-1:0]        duration_us,
    output logic                              fq_valid,
    output tram_pkg::tram_item_t              fq_item,
    input  logic                              fq_take
);
    import tram_pkg::*;

    tram_item_t slot_q [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       keep;
    logic       enq;
    logic       deq;
    tram_item_t item_in;

    // out-of-range records are taken and dropped here
    assign keep = (kind == KIND_SNAPSHOT) || (task_index < IN_IDX_W'(NUM_TASKS));
    assign full = (count_reg == 2'd2);
    assign enq  = push && !full && keep;
    assign deq  = fq_take && (count_reg != 2'd0);

    assign item_in.kind = kind;
    assign item_in.idx  = task_index[SLOT_W-1:0];
    assign item_in.dur  = duration_us;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ enq;
        rd_ptr_next = rd_ptr_reg ^ deq;
        count_next  = count_reg + {1'b0, enq} - {1'b0, deq};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            slot_q[wr_ptr_reg] <= item_in;
        end
    end

    assign fq_valid = (count_reg != 2'd0);
    assign fq_item  = slot_q[rd_ptr_reg];

endmodule

// ===== rtl/tram_div.sv =====
module tram_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tram_pkg::TOT_W-1:0]   dividend,
    input  logic [tram_pkg::CNT_W-1:0]   divisor,
    output logic                         busy,
    output logic [tram_pkg::AVG_W-1:0]   quotient
);
    import tram_pkg::*;

    logic [TOT_W-1:0]  dq_reg, dq_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  d_reg, d_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, dq_reg[TOT_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = (trial >= {1'b0, d_reg});

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            d_next    = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dq_next   = {dq_reg[TOT_W-2:0], ge};
            rem_next  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(TOT_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        d_reg    <= d_next;
        step_reg <= step_next;
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg[AVG_W-1:0];

endmodule

// ===== rtl/tram_back.sv =====
module tram_back #(
    parameter int NUM_TASKS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fq_valid,
    input  tram_pkg::tram_item_t           fq_item,
    output logic                           fq_take,
    input  logic                           out_take,
    output logic                           out_valid,
    output logic [tram_pkg::SLOT_W-1:0]    slot,
    output logic [tram_pkg::AVG_W-1:0]     average_us,
    output logic [tram_pkg::CNT_W-1:0]     sample_total,
    output logic                           last
);
    import tram_pkg::*;

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    tram_state_t          state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [DUR_W-1:0]     dur_reg, dur_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [NUM_TASKS-1:0] valid_reg, valid_next;
    logic                 hit_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]    slot_reg;
    logic [AVG_W-1:0]     avg_reg;
    logic [CNT_W-1:0]     total_reg;
    logic                 last_reg;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [ENTRY_W-1:0]   entry;
    logic [TOT_W-1:0]     entry_tot;
    logic [CNT_W-1:0]     entry_cnt;

    logic                 div_start;
    logic                 div_busy;
    logic [AVG_W-1:0]     div_q;

    logic                 out_free;
    logic                 out_push;
    logic                 at_last;

    tram_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_TASKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tram_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (entry_tot),
        .divisor  (entry_cnt),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // entries not written since the last clear read as zero
    assign entry     = hit_reg ? ram_rdata : '0;
    assign entry_tot = entry[ENTRY_W-1:CNT_W];
    assign entry_cnt = entry[CNT_W-1:0];
    assign ram_wdata = {entry_tot + TOT_W'(dur_reg), entry_cnt + 1'b1};
    assign ram_raddr = (state_reg == ST_IDLE) ? fq_item.idx[IDX_W-1:0] : idx_reg;

    assign out_free = !out_valid_reg || out_take;
    assign at_last  = (idx_reg == IDX_W'(NUM_TASKS - 1));

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        dur_next   = dur_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        fq_take    = 1'b0;
        ram_we     = 1'b0;
        div_start  = 1'b0;
        out_push   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (fq_valid)
                begin
                    fq_take = 1'b1;
                    if (fq_item.kind == KIND_RECORD)
                    begin
                        idx_next   = fq_item.idx[IDX_W-1:0];
                        dur_next   = fq_item.dur;
                        state_next = ST_REC_WR;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_SNAP_RD;
                    end
                end
            end
            ST_REC_WR:
            begin
                ram_we              = 1'b1;
                valid_next[idx_reg] = 1'b1;
                state_next          = ST_IDLE;
            end
            ST_SNAP_RD:
            begin
                state_next = ST_SNAP_LD;
            end
            ST_SNAP_LD:
            begin
                div_start           = 1'b1;
                cnt_next            = entry_cnt;
                valid_next[idx_reg] = 1'b0;
                state_next          = ST_SNAP_DV;
            end
            ST_SNAP_DV:
            begin
                if (!div_busy && out_free)
                begin
                    out_push = 1'b1;
                    if (at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SNAP_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        dur_reg <= dur_next;
        cnt_reg <= cnt_next;
        hit_reg <= valid_reg[ram_raddr];
        if (out_push)
        begin
            slot_reg  <= SLOT_W'(idx_reg);
            avg_reg   <= (cnt_reg == '0) ? '0 : div_q;
            total_reg <= cnt_reg;
            last_reg  <= at_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot         = slot_reg;
    assign average_us   = avg_reg;
    assign sample_total = total_reg;
    assign last         = last_reg;

endmodule

// ===== rtl/tram_chk.sv =====
module tram_chk #(
    parameter int NUM_TASKS = 8
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic [tram_pkg::SLOT_W-1:0]   slot,
    input logic [tram_pkg::AVG_W-1:0]    average_us,
    input logic [tram_pkg::CNT_W-1:0]    sample_total,
    input logic                          last
);
    import tram_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(slot) && $stable(average_us)
            && $stable(sample_total) && $stable(last))
        else $error("result changed while waiting");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> slot < SLOT_W'(NUM_TASKS))
        else $error("slot out of range");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> last == (slot == SLOT_W'(NUM_TASKS - 1)))
        else $error("last mark wrong");

    a_slot_seq: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !last |=> empty || slot == SLOT_W'($past(slot) + 1'b1))
        else $error("slot order broken");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && last |=> empty || slot == '0)
        else $error("next snapshot run not starting at slot 0");

endmodule

bind task_runtime_average_monitor tram_chk #(
    .NUM_TASKS (NUM_TASKS)
) u_tram_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .slot         (slot),
    .average_us   (average_us),
    .sample_total (sample_total),
    .last         (last)
);
